// ===== design/lwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Lock-wait tracking table package
// Request codes, status codes and the request record shared by the table
// control and the entry match logic.
// ----------------------------------------------------------------------------
`default_nettype none

package lwt_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_WAIT      = 2'd0,
    OP_ACQUIRED  = 2'd1,
    OP_RELEASED  = 2'd2,
    OP_CANCELLED = 2'd3
  } op_t;

  // Response status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // Entry phase codes
  localparam logic [1:0] PHASE_WAITING  = 2'd1;
  localparam logic [1:0] PHASE_ACQUIRED = 2'd2;

  // Entry kind that marks a free entry
  localparam logic [1:0] KIND_FREE = 2'd0;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int KIND_W   = 2;
  localparam int TASKIN_W = 16;
  localparam int LINE_W   = 16;
  localparam int PHASE_W  = 2;
  localparam int SLOT_W   = 6;

  // One request as captured from the input channel
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [KIND_W-1:0]   kind;
    logic                wr;
    logic [TASKIN_W-1:0] task_id;
    logic [LINE_W-1:0]   line;
  } req_t;

endpackage

`default_nettype wire

// ===== design/lock_wait_tracking_table.sv =====
`default_nettype none
// Operation: a request scans the entry memory from entry 0, one read per cycle;
// each registered read is compared while the next read is issued, and a hit or
// the compare of the last entry leads to the response state, which raises
// out_tvalid once the output register is free. One request at a time; in_tready
// rises in the same cycle as out_tvalid. The single read port sets the rate.
// Reset: after rst_n the block sweeps the memory marking every entry free;
// in_tready stays low during the sweep.
// ----------------------------------------------------------------------------
// Lock-wait tracking table
// Keeps wait and hold records of tasks on locks in one entry memory; each
// request scans for the first free or matching entry and updates it.
// ----------------------------------------------------------------------------

module lock_wait_tracking_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int TASK_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] opcode, [33:2] lock_address, [35:34] lock_kind, [36] write_access,
  // [52:37] task_id, [68:53] source_line, [71:69] zero
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [7:2] slot
  output logic      [7:0]  out_tdata
);

  import lwt_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = 53 + 2 * TASK_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W:0]    rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  req_t              req_r, req_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [IDX_W-1:0]  slot_idx_r, slot_idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic              hit;
  logic [ENTRY_W-1:0] new_word;
  logic              in_acc;
  logic              last_rd;
  logic              last_cmp;
  logic [IDX_W+SLOT_W-1:0] slot_wide;
  req_t              in_req;

  // Unpack the input transaction
  assign in_req.op      = op_t'(in_tdata[1:0]);
  assign in_req.addr    = in_tdata[33:2];
  assign in_req.kind    = in_tdata[35:34];
  assign in_req.wr      = in_tdata[36];
  assign in_req.task_id = in_tdata[52:37];
  assign in_req.line    = in_tdata[68:53];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign last_rd   = (rd_idx_r[IDX_W-1:0] == IDX_W'(TABLE_DEPTH - 1));
  assign last_cmp  = (cmp_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign ram_rd_en = (state_r == S_SCAN) && (rd_idx_r < (IDX_W + 1)'(TABLE_DEPTH));
  assign slot_wide = {{SLOT_W{1'b0}}, slot_idx_r};

  lwt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  lwt_match #(
    .TASK_BITS (TASK_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_match (
    .req        (req_r),
    .entry_word (ram_rd_data),
    .hit        (hit),
    .new_word   (new_word)
  );

  // Sequence clear sweep, scan, write-back and response
  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    req_nxt      = req_r;
    status_nxt   = status_r;
    slot_idx_nxt = slot_idx_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = cmp_idx_r;
    ram_wr_data  = new_word;

    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = rd_idx_r[IDX_W-1:0];
        ram_wr_data = '0;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        if (last_rd) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_req;
          rd_idx_nxt = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next read while comparing the previous one
        if (ram_rd_en) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (cmp_vld_r && hit) begin
          ram_wr_en    = 1'b1;
          status_nxt   = ST_DONE;
          slot_idx_nxt = cmp_idx_r;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = S_RESP;
        end else if (cmp_vld_r && last_cmp) begin
          status_nxt   = (req_r.op == OP_WAIT) ? ST_FULL : ST_NOMATCH;
          slot_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        // Hold until the output register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {slot_wide[SLOT_W-1:0], status_r};
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cmp_idx_r  <= cmp_idx_nxt;
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    slot_idx_r <= slot_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // A new request is only taken with no compare in flight
  a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmp_vld_r)
    else $error("request accepted while a compare is pending");

  // The compared entry is always the one read just before the next read
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_vld_r && ram_rd_en) |-> (rd_idx_r == ({1'b0, cmp_idx_r} + 1'b1)))
    else $error("scan read and compare indexes out of step");

  // A new response only comes from the response state
  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(state_r == S_RESP))
    else $error("response raised outside the response state");

endmodule

`default_nettype wire

// ===== design/lwt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lwt_match.sv =====
// ----------------------------------------------------------------------------
// Lock-wait entry match
// Compares one stored entry with the current request and forms the
// write-back word for a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module lwt_match #(
  parameter int TASK_BITS = 16,
  parameter int ENTRY_W   = 53 + 2 * TASK_BITS
) (
  input  wire lwt_pkg::req_t        req,
  input  wire logic [ENTRY_W-1:0]   entry_word,
  output logic                      hit,
  output logic      [ENTRY_W-1:0]   new_word
);

  import lwt_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ADDR_W-1:0]    addr;
    logic                 wr;
    logic [TASK_BITS-1:0] waiter;
    logic [TASK_BITS-1:0] holder;
    logic [LINE_W-1:0]    line;
    logic [PHASE_W-1:0]   phase;
  } entry_t;

  entry_t                      cur;
  entry_t                      upd;
  logic [TASK_BITS+TASKIN_W-1:0] task_wide;
  logic [TASK_BITS-1:0]        task_v;
  logic                        valid;
  logic                        key_eq;

  // Fit the task id to the stored task width
  assign task_wide = {{TASK_BITS{1'b0}}, req.task_id};
  assign task_v    = task_wide[TASK_BITS-1:0];

  assign cur    = entry_t'(entry_word);
  assign valid  = (cur.kind != KIND_FREE);
  assign key_eq = valid && (cur.addr == req.addr) && (cur.wr == req.wr);

  // Decide hit and build the updated entry
  always_comb begin
    upd = cur;
    hit = 1'b0;
    unique case (req.op)
      OP_WAIT: begin
        hit        = !valid;
        upd.kind   = req.kind;
        upd.addr   = req.addr;
        upd.wr     = req.wr;
        upd.waiter = task_v;
        upd.holder = '0;
        upd.line   = req.line;
        upd.phase  = PHASE_WAITING;
      end
      OP_ACQUIRED: begin
        hit        = key_eq && (cur.waiter == task_v);
        upd.phase  = PHASE_ACQUIRED;
        upd.holder = task_v;
        upd.waiter = '0;
      end
      OP_RELEASED: begin
        hit      = key_eq && (cur.holder == task_v);
        upd.kind = KIND_FREE;
      end
      OP_CANCELLED: begin
        hit      = key_eq && (cur.waiter == task_v);
        upd.kind = KIND_FREE;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign new_word = ENTRY_W'(upd);

endmodule

`default_nettype wire
